// ===== sv/isia_pkg.sv =====
// ----------------------------------------------------------------------------
// isia_pkg
// Shared constants, register indexes and structs of the swathe interleave
// addresser.
// ----------------------------------------------------------------------------
package isia_pkg;

    // head and image limits
    localparam int HEAD_NOZZLES = 1024;
    localparam int MAX_WIDTH    = 16384;
    localparam int MAX_PASSES   = 16;

    // field widths
    localparam int NOZZLE_W   = 10;
    localparam int COL_W      = 14;
    localparam int ROW_W      = 14;
    localparam int STEP_W     = 14;
    localparam int PASS_W     = 4;
    localparam int SWATHE_W   = 14;
    localparam int RATIO_W    = 5;
    localparam int NZ_CFG_W   = 12;
    localparam int DIM_W      = 15;
    localparam int USED_W     = NOZZLE_W + 1;
    localparam int SPAN_W     = 15;
    localparam int BASE_W     = 24;
    localparam int PROD_W     = STEP_W + SPAN_W;
    localparam int OFFS_W     = NOZZLE_W + RATIO_W;
    localparam int COLSUM_W   = BASE_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PASS_RATIO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_NOZZLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_NOZZLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // clamped swathe geometry derived from the registers
    typedef struct packed {
        logic                ratio_zero;
        logic [RATIO_W-1:0]  ratio;
        logic [NOZZLE_W-1:0] start_noz;
        logic [NOZZLE_W-1:0] end_noz;
        logic [SPAN_W-1:0]   span;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } isia_geom_t;

    // one result word
    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [NOZZLE_W-1:0] nozzle;
        logic [STEP_W-1:0]   step_index;
        logic [PASS_W-1:0]   pass_index;
        logic [SWATHE_W-1:0] swathe_index;
        logic                fetch;
        logic                last_of_swathe;
        logic                done_res;
        logic                config_error;
    } isia_result_t;

endpackage

// ===== sv/isia_cfg.sv =====
// ----------------------------------------------------------------------------
// isia_cfg
// Configuration registers and the registered, clamped swathe geometry.
// ----------------------------------------------------------------------------
module isia_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [isia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isia_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output isia_pkg::isia_geom_t                geom
);

    logic [isia_pkg::RATIO_W-1:0]  pass_ratio_reg;
    logic [isia_pkg::NZ_CFG_W-1:0] start_nozzle_reg;
    logic [isia_pkg::NZ_CFG_W-1:0] end_nozzle_reg;
    logic [isia_pkg::DIM_W-1:0]    image_width_reg;
    logic [isia_pkg::DIM_W-1:0]    image_height_reg;

    logic [isia_pkg::RATIO_W-1:0]        ratio_sat;
    logic [isia_pkg::NOZZLE_W-1:0]       endn;
    logic [isia_pkg::NOZZLE_W-1:0]       startn;
    logic [isia_pkg::USED_W-1:0]         used;
    logic [isia_pkg::USED_W+isia_pkg::RATIO_W-1:0] span_full;
    isia_pkg::isia_geom_t                geom_next;
    isia_pkg::isia_geom_t                geom_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_ratio_reg   <= isia_pkg::RATIO_W'(1);
            start_nozzle_reg <= '0;
            end_nozzle_reg   <= '0;
            image_width_reg  <= isia_pkg::DIM_W'(1);
            image_height_reg <= isia_pkg::DIM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                isia_pkg::REG_PASS_RATIO:   pass_ratio_reg   <= cfg_wdata[isia_pkg::RATIO_W-1:0];
                isia_pkg::REG_START_NOZZLE: start_nozzle_reg <= cfg_wdata[isia_pkg::NZ_CFG_W-1:0];
                isia_pkg::REG_END_NOZZLE:   end_nozzle_reg   <= cfg_wdata[isia_pkg::NZ_CFG_W-1:0];
                isia_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[isia_pkg::DIM_W-1:0];
                isia_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[isia_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamping of ratio, nozzle window and image size
    always_comb begin
        ratio_sat = (pass_ratio_reg > isia_pkg::RATIO_W'(isia_pkg::MAX_PASSES))
                  ? isia_pkg::RATIO_W'(isia_pkg::MAX_PASSES) : pass_ratio_reg;
        endn = (end_nozzle_reg >= isia_pkg::NZ_CFG_W'(isia_pkg::HEAD_NOZZLES))
             ? isia_pkg::NOZZLE_W'(isia_pkg::HEAD_NOZZLES - 1)
             : end_nozzle_reg[isia_pkg::NOZZLE_W-1:0];
        startn = (start_nozzle_reg > isia_pkg::NZ_CFG_W'(endn))
               ? endn : start_nozzle_reg[isia_pkg::NOZZLE_W-1:0];
        used = isia_pkg::USED_W'(endn) - isia_pkg::USED_W'(startn) + isia_pkg::USED_W'(1);
        span_full = (isia_pkg::USED_W+isia_pkg::RATIO_W)'(used)
                  * (isia_pkg::USED_W+isia_pkg::RATIO_W)'(ratio_sat);

        geom_next.ratio_zero = (pass_ratio_reg == '0);
        geom_next.ratio      = ratio_sat;
        geom_next.start_noz  = startn;
        geom_next.end_noz    = endn;
        geom_next.span       = span_full[isia_pkg::SPAN_W-1:0];
        geom_next.width      = (image_width_reg > isia_pkg::DIM_W'(isia_pkg::MAX_WIDTH))
                             ? isia_pkg::DIM_W'(isia_pkg::MAX_WIDTH) : image_width_reg;
        geom_next.height     = (image_height_reg > isia_pkg::DIM_W'(isia_pkg::MAX_WIDTH))
                             ? isia_pkg::DIM_W'(isia_pkg::MAX_WIDTH) : image_height_reg;
    end

    // geometry register, follows the configuration registers in the next cycle
    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

// ===== sv/isia_walk.sv =====
// ----------------------------------------------------------------------------
// isia_walk
// Walk counters (step, pass, row, nozzle, swathe) and the position logic
// that turns them into one result word per advance.
// ----------------------------------------------------------------------------
module isia_walk (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  isia_pkg::isia_geom_t   geom,
    input  logic                   advance,
    input  logic                   restart,
    output isia_pkg::isia_result_t res
);

    logic [isia_pkg::STEP_W-1:0]   step_count_reg,   step_count_next;
    logic [isia_pkg::PASS_W-1:0]   pass_count_reg,   pass_count_next;
    logic [isia_pkg::ROW_W-1:0]    row_count_reg,    row_count_next;
    logic [isia_pkg::NOZZLE_W-1:0] nozzle_count_reg, nozzle_count_next;
    logic [isia_pkg::SWATHE_W-1:0] swathe_count_reg, swathe_count_next;
    logic [isia_pkg::BASE_W-1:0]   pass_base_reg,    pass_base_next;
    logic                          walk_done_reg,    walk_done_next;

    // state as seen by this word, after an optional restart
    logic [isia_pkg::STEP_W-1:0]   cur_step;
    logic [isia_pkg::PASS_W-1:0]   cur_pass;
    logic [isia_pkg::ROW_W-1:0]    cur_row;
    logic [isia_pkg::NOZZLE_W-1:0] cur_noz;
    logic [isia_pkg::SWATHE_W-1:0] cur_swathe;
    logic [isia_pkg::BASE_W-1:0]   cur_base;
    logic                          cur_done;

    logic [isia_pkg::PROD_W-1:0]   prod;
    logic [isia_pkg::PROD_W-1:0]   width_x;
    logic                          in_range;
    logic                          pass_ok;
    logic                          row_ok;
    logic                          skip_pass;
    logic                          pos_valid;
    logic                          win;
    logic [isia_pkg::NOZZLE_W-1:0] noz_delta;
    logic [isia_pkg::OFFS_W-1:0]   offs;
    logic [isia_pkg::COLSUM_W-1:0] col;
    logic                          fetch;
    logic                          noz_last;
    logic [isia_pkg::DIM_W-1:0]    row_inc;
    logic                          row_wrap;
    logic [isia_pkg::RATIO_W-1:0]  pass_inc;
    logic                          pass_wrap;
    logic                          step_end;

    // restart view of the counters
    always_comb begin
        cur_step   = restart ? '0 : step_count_reg;
        cur_pass   = restart ? '0 : pass_count_reg;
        cur_row    = restart ? '0 : row_count_reg;
        cur_noz    = restart ? '0 : nozzle_count_reg;
        cur_swathe = restart ? '0 : swathe_count_reg;
        cur_base   = restart ? '0 : pass_base_reg;
        cur_done   = restart ? 1'b0 : walk_done_reg;
    end

    // position checks against the current geometry
    always_comb begin
        prod      = isia_pkg::PROD_W'(cur_step) * isia_pkg::PROD_W'(geom.span);
        width_x   = isia_pkg::PROD_W'(geom.width);
        in_range  = prod < width_x;
        pass_ok   = isia_pkg::RATIO_W'(cur_pass) < geom.ratio;
        row_ok    = isia_pkg::DIM_W'(cur_row) < geom.height;
        // a pass of the last step whose base column lies past the width
        skip_pass = (prod + isia_pkg::PROD_W'(cur_pass)) >= width_x;
        pos_valid = !cur_done && in_range && pass_ok && row_ok && !skip_pass;
    end

    // image column of this nozzle
    always_comb begin
        win       = (cur_noz >= geom.start_noz) && (cur_noz <= geom.end_noz);
        noz_delta = cur_noz - geom.start_noz;
        offs      = isia_pkg::OFFS_W'(noz_delta) * isia_pkg::OFFS_W'(geom.ratio);
        col       = isia_pkg::COLSUM_W'(cur_base) + isia_pkg::COLSUM_W'(offs);
        fetch     = win && (col < isia_pkg::COLSUM_W'(geom.width));
    end

    // counter carries
    always_comb begin
        noz_last  = cur_noz == isia_pkg::NOZZLE_W'(isia_pkg::HEAD_NOZZLES - 1);
        row_inc   = isia_pkg::DIM_W'(cur_row) + isia_pkg::DIM_W'(1);
        row_wrap  = row_inc >= geom.height;
        pass_inc  = isia_pkg::RATIO_W'(cur_pass) + isia_pkg::RATIO_W'(1);
        pass_wrap = (pass_inc >= geom.ratio)
                 || ((prod + isia_pkg::PROD_W'(pass_inc)) >= width_x);
        step_end  = (prod + isia_pkg::PROD_W'(geom.span)) >= width_x;
    end

    // result word
    always_comb begin
        res = '0;
        if (geom.ratio_zero) begin
            res.config_error = 1'b1;
        end else if (!pos_valid) begin
            res.done_res = 1'b1;
        end else begin
            res.column         = fetch ? col[isia_pkg::COL_W-1:0] : '0;
            res.row            = cur_row;
            res.nozzle         = cur_noz;
            res.step_index     = cur_step;
            res.pass_index     = cur_pass;
            res.swathe_index   = cur_swathe;
            res.fetch          = fetch;
            res.last_of_swathe = noz_last && (row_inc == geom.height);
        end
    end

    // next walk state
    always_comb begin
        step_count_next   = cur_step;
        pass_count_next   = cur_pass;
        row_count_next    = cur_row;
        nozzle_count_next = cur_noz;
        swathe_count_next = cur_swathe;
        pass_base_next    = cur_base;
        walk_done_next    = cur_done;
        if (!geom.ratio_zero) begin
            if (!pos_valid) begin
                walk_done_next = 1'b1;
            end else begin
                nozzle_count_next = cur_noz + isia_pkg::NOZZLE_W'(1);
                if (noz_last) begin
                    if (!row_wrap) begin
                        row_count_next = row_inc[isia_pkg::ROW_W-1:0];
                    end else begin
                        row_count_next    = '0;
                        swathe_count_next = cur_swathe + isia_pkg::SWATHE_W'(1);
                        if (pass_wrap) begin
                            pass_count_next = '0;
                            step_count_next = cur_step + isia_pkg::STEP_W'(1);
                            walk_done_next  = step_end;
                            pass_base_next  = isia_pkg::BASE_W'(prod
                                            + isia_pkg::PROD_W'(geom.span));
                        end else begin
                            pass_count_next = pass_inc[isia_pkg::PASS_W-1:0];
                            pass_base_next  = isia_pkg::BASE_W'(prod
                                            + isia_pkg::PROD_W'(pass_inc));
                        end
                    end
                end
            end
        end
    end

    // walk state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg   <= '0;
            pass_count_reg   <= '0;
            row_count_reg    <= '0;
            nozzle_count_reg <= '0;
            swathe_count_reg <= '0;
            pass_base_reg    <= '0;
            walk_done_reg    <= 1'b0;
        end else if (advance) begin
            step_count_reg   <= step_count_next;
            pass_count_reg   <= pass_count_next;
            row_count_reg    <= row_count_next;
            nozzle_count_reg <= nozzle_count_next;
            swathe_count_reg <= swathe_count_next;
            pass_base_reg    <= pass_base_next;
            walk_done_reg    <= walk_done_next;
        end
    end

endmodule

// ===== sv/inkjet_swathe_interleave_addresser_top.sv =====
// ----------------------------------------------------------------------------
// inkjet_swathe_interleave_addresser_top
// Multi-pass swathe interleave address generator for an inkjet head.
// ----------------------------------------------------------------------------
// Every input word (restart flag) yields exactly one result word giving the
// next swathe byte position: image column, row, nozzle, step, pass, swathe
// count and the fetch / pad, end-of-swathe, done and config-error flags.
// Throughput is one word per clock unless the result channel stalls. A result
// word passes the input register, then the result register; the walk counters
// update in the same cycle the result is registered. A configuration write
// reaches the clamped geometry via the configuration and geometry registers.
// After the walk ends, done_res is returned until a word with restart set.
module inkjet_swathe_interleave_addresser_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [isia_pkg::COL_W-1:0]          m_column,
    output logic [isia_pkg::ROW_W-1:0]          m_row,
    output logic [isia_pkg::NOZZLE_W-1:0]       m_nozzle,
    output logic [isia_pkg::STEP_W-1:0]         m_step_index,
    output logic [isia_pkg::PASS_W-1:0]         m_pass_index,
    output logic [isia_pkg::SWATHE_W-1:0]       m_swathe_index,
    output logic                                m_fetch,
    output logic                                m_last_of_swathe,
    output logic                                m_done_res,
    output logic                                m_config_error,
    // configuration port
    input  logic                                cfg_we,
    input  logic [isia_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isia_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    isia_pkg::isia_geom_t   geom;
    isia_pkg::isia_result_t walk_res;

    logic                   in_valid_reg,  in_valid_next;
    logic                   in_restart_reg;
    logic                   out_valid_reg, out_valid_next;
    isia_pkg::isia_result_t out_res_reg;
    logic                   advance;

    isia_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    isia_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .advance (advance),
        .restart (in_restart_reg),
        .res     (walk_res)
    );

    // pipeline handshake
    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result words
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_restart_reg <= s_restart;
        end
        if (advance) begin
            out_res_reg <= walk_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_column         = out_res_reg.column;
    assign m_row            = out_res_reg.row;
    assign m_nozzle         = out_res_reg.nozzle;
    assign m_step_index     = out_res_reg.step_index;
    assign m_pass_index     = out_res_reg.pass_index;
    assign m_swathe_index   = out_res_reg.swathe_index;
    assign m_fetch          = out_res_reg.fetch;
    assign m_last_of_swathe = out_res_reg.last_of_swathe;
    assign m_done_res       = out_res_reg.done_res;
    assign m_config_error   = out_res_reg.config_error;

endmodule
